>>> rtl/brb_pkg.sv
package brb_pkg;

   // Default geometry of the buffer.
   localparam int CAPACITY_DEF     = 4096;
   localparam int MAX_TRANSFER_DEF = 64;

   // Fixed field widths of the request and response items.
   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 7;
   localparam int KIND_W      = 2;
   localparam int COUNT_OUT_W = 13;

   // Stream bus widths: request data is byte plus length, padded to 16 bits;
   // response data is byte plus two counts, padded to 40 bits.
   localparam int REQ_DATA_W = 16;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 2;

   // Entries in the command queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   // Request kinds carried in the low bits of req_tuser.
   typedef enum logic [KIND_W-1:0] {
      REQ_ENQUEUE = 2'd0,
      REQ_DEQUEUE = 2'd1,
      REQ_PEEK    = 2'd2,
      REQ_CLEAR   = 2'd3
   } req_kind_type;

   // Work handed from the front to the back.
   typedef enum logic [1:0] {
      CMD_NOTE  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_READ  = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type            kind;
      logic                    refused;
      logic [BYTE_W-1:0]       data;
      logic [LEN_W-1:0]        length;
      logic [COUNT_OUT_W-1:0]  used_bytes;
      logic [COUNT_OUT_W-1:0]  free_bytes;
   } cmd_type;

   // One response item.
   typedef struct packed {
      logic [BYTE_W-1:0]       out_byte;
      logic                    has_data;
      logic                    refused;
      logic                    last;
      logic [COUNT_OUT_W-1:0]  used_bytes;
      logic [COUNT_OUT_W-1:0]  free_bytes;
   } res_type;

endpackage

>>> rtl/brb_front.sv
module brb_front #(
   parameter int CAPACITY     = brb_pkg::CAPACITY_DEF,
   parameter int MAX_TRANSFER = brb_pkg::MAX_TRANSFER_DEF,
   parameter int PTR_W        = $clog2(CAPACITY)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_accept,
   input  brb_pkg::req_kind_type         req_kind,
   input  logic [brb_pkg::BYTE_W-1:0]    in_byte,
   input  logic                          run_start,
   input  logic [brb_pkg::LEN_W-1:0]     req_length,
   output brb_pkg::cmd_type              cmd,
   output logic [PTR_W-1:0]              cmd_addr
);

   localparam int LEN_W  = brb_pkg::LEN_W;
   localparam int OUT_W  = brb_pkg::COUNT_OUT_W;
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int SUM_W  = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 1;
   localparam int CMP_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
   localparam logic [SUM_W-1:0] CAP_SUM = SUM_W'(CAPACITY);
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_TRANSFER);

   // Base plus offset, folded back into the buffer; the sum stays below
   // twice the capacity, so one subtraction suffices.
   function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                 input logic [LEN_W-1:0] step);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(step);
      if (sum >= CAP_SUM) begin
         sum = sum - CAP_SUM;
      end
      return sum[PTR_W-1:0];
   endfunction

   // Counts are reported modulo 2^13.
   function automatic logic [OUT_W-1:0] out_count(input logic [CNT_W-1:0] c);
      logic [CNT_W+OUT_W-1:0] wide;
      wide = (CNT_W + OUT_W)'(c);
      return wide[OUT_W-1:0];
   endfunction

   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [LEN_W-1:0] run_rem_ff, run_rem_in;
   logic             run_acc_ff, run_acc_in;
   logic [LEN_W-1:0] run_off_ff, run_off_in;

   logic [CNT_W-1:0] free_cnt;
   logic             fits;
   logic             have_data;
   logic             len_bad;
   logic [LEN_W-1:0] eff_rem;
   logic             eff_acc;
   logic [LEN_W-1:0] eff_off;
   logic [LEN_W-1:0] new_rem;
   logic [LEN_W-1:0] new_off;
   brb_pkg::cmd_kind_type kind;
   logic             refused;

   // Run bookkeeping as seen by this byte: a run start opens a fresh run.
   assign free_cnt  = CAP_CNT - count_ff;
   assign fits      = CMP_W'(free_cnt) >= CMP_W'(req_length);
   assign have_data = CMP_W'(count_ff) >= CMP_W'(req_length);
   assign len_bad   = (req_length == '0) || (req_length > MAX_LEN);
   assign eff_rem   = run_start ? req_length : run_rem_ff;
   assign eff_acc   = run_start ? fits : run_acc_ff;
   assign eff_off   = run_start ? '0 : run_off_ff;
   assign new_rem   = eff_rem - LEN_W'(1);
   assign new_off   = eff_off + LEN_W'(1);

   // Classify the request and work out the pointer state after it.
   always_comb begin
      rd_ptr_in  = rd_ptr_ff;
      wr_ptr_in  = wr_ptr_ff;
      count_in   = count_ff;
      run_rem_in = run_rem_ff;
      run_acc_in = run_acc_ff;
      run_off_in = run_off_ff;
      kind       = brb_pkg::CMD_NOTE;
      refused    = 1'b0;
      cmd_addr   = wr_ptr_ff;
      case (req_kind)
         brb_pkg::REQ_ENQUEUE: begin
            if (run_start ? len_bad : (run_rem_ff == '0)) begin
               // Bad run length or a stray byte: refuse, no run left open.
               refused    = 1'b1;
               run_rem_in = '0;
               run_acc_in = 1'b0;
               run_off_in = '0;
            end else if (eff_acc) begin
               kind     = brb_pkg::CMD_WRITE;
               cmd_addr = wrap_add(wr_ptr_ff, eff_off);
               if (new_rem == '0) begin
                  // Final byte of the run commits it.
                  wr_ptr_in  = wrap_add(wr_ptr_ff, new_off);
                  count_in   = count_ff + CNT_W'(new_off);
                  run_rem_in = '0;
                  run_acc_in = 1'b0;
                  run_off_in = '0;
               end else begin
                  run_rem_in = new_rem;
                  run_acc_in = 1'b1;
                  run_off_in = new_off;
               end
            end else begin
               // Run without space: every byte of it is dropped.
               refused    = 1'b1;
               run_rem_in = new_rem;
               run_acc_in = 1'b0;
               run_off_in = '0;
            end
         end
         brb_pkg::REQ_DEQUEUE, brb_pkg::REQ_PEEK: begin
            if (req_length == '0) begin
               refused = 1'b0;
            end else if ((req_length > MAX_LEN) || !have_data) begin
               refused = 1'b1;
            end else begin
               kind     = brb_pkg::CMD_READ;
               cmd_addr = rd_ptr_ff;
               if (req_kind == brb_pkg::REQ_DEQUEUE) begin
                  rd_ptr_in = wrap_add(rd_ptr_ff, req_length);
                  count_in  = count_ff - CNT_W'(req_length);
               end
            end
         end
         brb_pkg::REQ_CLEAR: begin
            rd_ptr_in  = '0;
            wr_ptr_in  = '0;
            count_in   = '0;
            run_rem_in = '0;
            run_acc_in = 1'b0;
            run_off_in = '0;
         end
         default: begin
            refused = 1'b1;
         end
      endcase
   end

   // Command for the back, carrying the counts after this request.
   always_comb begin
      cmd.kind       = kind;
      cmd.refused    = refused;
      cmd.data       = in_byte;
      cmd.length     = req_length;
      cmd.used_bytes = out_count(count_in);
      cmd.free_bytes = out_count(CAP_CNT - count_in);
   end

   // Pointer and run state move on every accepted transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff  <= '0;
         wr_ptr_ff  <= '0;
         count_ff   <= '0;
         run_rem_ff <= '0;
         run_acc_ff <= 1'b0;
         run_off_ff <= '0;
      end else if (req_accept) begin
         rd_ptr_ff  <= rd_ptr_in;
         wr_ptr_ff  <= wr_ptr_in;
         count_ff   <= count_in;
         run_rem_ff <= run_rem_in;
         run_acc_ff <= run_acc_in;
         run_off_ff <= run_off_in;
      end
   end

endmodule

>>> rtl/brb_queue.sv
module brb_queue #(
   parameter int WIDTH = 1,
   parameter int DEPTH = brb_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data,
   output logic             full
);

   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(DEPTH);

   logic [WIDTH-1:0]  entries_ff [DEPTH];
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]  wr_idx_ff, wr_idx_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   assign head_valid = fill_ff != '0;
   assign full       = fill_ff == FULL_FILL;
   assign head_data  = entries_ff[rd_idx_ff];

   // Ring indices and fill level.
   always_comb begin
      rd_idx_in = rd_idx_ff;
      wr_idx_in = wr_idx_ff;
      if (pop) begin
         rd_idx_in = (rd_idx_ff == LAST_IDX) ? '0 : rd_idx_ff + IDX_W'(1);
      end
      if (push) begin
         wr_idx_in = (wr_idx_ff == LAST_IDX) ? '0 : wr_idx_ff + IDX_W'(1);
      end
      case ({push, pop})
         2'b10:   fill_in = fill_ff + FILL_W'(1);
         2'b01:   fill_in = fill_ff - FILL_W'(1);
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff <= '0;
         wr_idx_ff <= '0;
         fill_ff   <= '0;
      end else begin
         rd_idx_ff <= rd_idx_in;
         wr_idx_ff <= wr_idx_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_idx_ff] <= push_data;
      end
   end

endmodule

>>> rtl/brb_back.sv
module brb_back #(
   parameter int CAPACITY = brb_pkg::CAPACITY_DEF,
   parameter int PTR_W    = $clog2(CAPACITY)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  brb_pkg::cmd_type  cmd,
   input  logic [PTR_W-1:0]  cmd_addr,
   output logic              cmd_pop,
   output logic              res_valid,
   input  logic              res_ready,
   output brb_pkg::res_type  res
);

   localparam int LEN_W  = brb_pkg::LEN_W;
   localparam int BYTE_W = brb_pkg::BYTE_W;
   localparam int SUM_W  = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 1;
   localparam logic [SUM_W-1:0] CAP_SUM = SUM_W'(CAPACITY);

   function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                 input logic [LEN_W-1:0] step);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(step);
      if (sum >= CAP_SUM) begin
         sum = sum - CAP_SUM;
      end
      return sum[PTR_W-1:0];
   endfunction

   logic [BYTE_W-1:0] store_ff [CAPACITY];
   logic [BYTE_W-1:0] mem_q_ff;

   logic [LEN_W-1:0]  step_ff, step_in;
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_from_mem_ff, s1_from_mem_in;
   brb_pkg::res_type  s1_res_ff, s1_res_in;
   logic              out_valid_ff, out_valid_in;
   brb_pkg::res_type  out_res_ff, out_res_in;

   logic              out_open;
   logic              s1_go;
   logic              s1_open;
   logic              issue;
   logic              is_read;
   logic              is_write;
   logic [LEN_W-1:0]  step_next;
   logic              last_step;
   logic [PTR_W-1:0]  rd_addr;

   // One step of the head command goes out whenever the issue stage is free.
   assign out_open  = !out_valid_ff || res_ready;
   assign s1_go     = s1_valid_ff && out_open;
   assign s1_open   = !s1_valid_ff || s1_go;
   assign issue     = cmd_valid && s1_open;
   assign is_read   = cmd.kind == brb_pkg::CMD_READ;
   assign is_write  = cmd.kind == brb_pkg::CMD_WRITE;
   assign step_next = step_ff + LEN_W'(1);
   assign last_step = step_next == cmd.length;
   assign rd_addr   = wrap_add(cmd_addr, step_ff);
   assign cmd_pop   = issue && (!is_read || last_step);

   // Issue stage: the step counter walks through a read stream.
   always_comb begin
      step_in        = step_ff;
      s1_valid_in    = s1_valid_ff;
      s1_from_mem_in = s1_from_mem_ff;
      s1_res_in      = s1_res_ff;
      if (s1_go) begin
         s1_valid_in = 1'b0;
      end
      if (issue) begin
         s1_valid_in          = 1'b1;
         s1_from_mem_in       = is_read;
         s1_res_in.out_byte   = '0;
         s1_res_in.used_bytes = cmd.used_bytes;
         s1_res_in.free_bytes = cmd.free_bytes;
         case (cmd.kind)
            brb_pkg::CMD_READ: begin
               s1_res_in.has_data = 1'b1;
               s1_res_in.refused  = 1'b0;
               s1_res_in.last     = last_step;
               step_in            = last_step ? '0 : step_next;
            end
            brb_pkg::CMD_WRITE: begin
               s1_res_in.has_data = 1'b0;
               s1_res_in.refused  = 1'b0;
               s1_res_in.last     = 1'b1;
            end
            default: begin
               s1_res_in.has_data = 1'b0;
               s1_res_in.refused  = cmd.refused;
               s1_res_in.last     = 1'b1;
            end
         endcase
      end
   end

   // Output register: the byte joins its result from the registered read data.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_res_in   = out_res_ff;
      if (res_ready) begin
         out_valid_in = 1'b0;
      end
      if (s1_go) begin
         out_valid_in        = 1'b1;
         out_res_in          = s1_res_ff;
         out_res_in.out_byte = s1_from_mem_ff ? mem_q_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_from_mem_ff <= s1_from_mem_in;
      s1_res_ff      <= s1_res_in;
      out_res_ff     <= out_res_in;
   end

   // Byte store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (issue && is_write) begin
         store_ff[cmd_addr] <= cmd.data;
      end
      if (issue && is_read) begin
         mem_q_ff <= store_ff[rd_addr];
      end
   end

   assign res_valid = out_valid_ff;
   assign res       = out_res_ff;

endmodule

>>> rtl/byte_ring_buffer.sv
// Circular byte FIFO with all-or-nothing requests. Each request transfer is
// one enqueue byte, one dequeue or peek of up to MAX_TRANSFER bytes, or a
// clear. An enqueue run is admitted or refused as a whole at its first byte,
// and its bytes become readable only once its final byte has arrived. Every
// enqueue byte, clear, zero-length or refused read gives one response; a
// read of N bytes gives N responses, the final one marked with tlast. Every
// response carries the used and free byte counts after its request. The
// front end decides each request in the cycle it is accepted and passes a
// command into a two-entry queue, so a request can be taken every cycle
// while the queue has room. The back end runs one command step per cycle,
// while the response side is not stalled, through the byte store's single
// read port: one step for an enqueue byte or a single response, N steps
// for an N-byte read. Each command passes through the queue, the issue
// stage and the output register. The store needs no clearing after reset.
module byte_ring_buffer #(
   parameter int CAPACITY     = brb_pkg::CAPACITY_DEF,
   parameter int MAX_TRANSFER = brb_pkg::MAX_TRANSFER_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // in_byte [7:0], req_length [14:8], zero [15]
   input  logic [brb_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req_type [1:0], run_start [2]
   input  logic [brb_pkg::REQ_USER_W-1:0]     req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // out_byte [7:0], used_bytes [20:8], free_bytes [33:21], zero [39:34]
   output logic [brb_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // has_data [0], refused [1]
   output logic [brb_pkg::RSP_USER_W-1:0]     rsp_tuser,
   output logic                               rsp_tlast
);

   localparam int PTR_W   = $clog2(CAPACITY);
   localparam int CMD_W   = $bits(brb_pkg::cmd_type);
   localparam int ENTRY_W = CMD_W + PTR_W;
   localparam int PAD_W   = brb_pkg::RSP_DATA_W - brb_pkg::BYTE_W
                            - 2 * brb_pkg::COUNT_OUT_W;

   logic                  req_accept;
   brb_pkg::req_kind_type req_kind;
   brb_pkg::cmd_type      front_cmd;
   logic [PTR_W-1:0]      front_addr;
   logic                  q_full;
   logic                  q_valid;
   logic                  q_pop;
   logic [ENTRY_W-1:0]    q_head;
   brb_pkg::cmd_type      back_cmd;
   logic [PTR_W-1:0]      back_addr;
   brb_pkg::res_type      res;

   assign req_tready = !q_full;
   assign req_accept = req_tvalid && req_tready;
   assign req_kind   = brb_pkg::req_kind_type'(req_tuser[1:0]);

   brb_front #(
      .CAPACITY     (CAPACITY),
      .MAX_TRANSFER (MAX_TRANSFER),
      .PTR_W        (PTR_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_kind   (req_kind),
      .in_byte    (req_tdata[7:0]),
      .run_start  (req_tuser[2]),
      .req_length (req_tdata[14:8]),
      .cmd        (front_cmd),
      .cmd_addr   (front_addr)
   );

   brb_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (brb_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_accept),
      .push_data  ({front_addr, front_cmd}),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (q_head),
      .full       (q_full)
   );

   assign back_cmd  = brb_pkg::cmd_type'(q_head[CMD_W-1:0]);
   assign back_addr = q_head[ENTRY_W-1:CMD_W];

   brb_back #(
      .CAPACITY (CAPACITY),
      .PTR_W    (PTR_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_valid),
      .cmd       (back_cmd),
      .cmd_addr  (back_addr),
      .cmd_pop   (q_pop),
      .res_valid (rsp_tvalid),
      .res_ready (rsp_tready),
      .res       (res)
   );

   // Pack the response transfer.
   assign rsp_tdata = {{PAD_W{1'b0}}, res.free_bytes, res.used_bytes, res.out_byte};
   assign rsp_tuser = {res.refused, res.has_data};
   assign rsp_tlast = res.last;

   // The back end only retires commands that are present.
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("command popped from an empty queue");

   // A refused response never carries a byte.
   assert property (@(posedge clock) disable iff (reset)
                    rsp_tvalid && rsp_tuser[1] |-> !rsp_tuser[0])
      else $error("refused response marked as carrying data");

   // Refusals and byte-less responses are single, so they always close the item.
   assert property (@(posedge clock) disable iff (reset)
                    rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast)
      else $error("response without data is not marked last");

   // A full queue holds the request side off until the back end pops.
   assert property (@(posedge clock) disable iff (reset)
                    q_full && !q_pop |=> q_full)
      else $error("queue level dropped without a pop");

endmodule
